// ===== rtl/qat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_pkg
// Shared constants, codes and types for the quorum acknowledgment tracker.
// ----------------------------------------------------------------------------
package qat_pkg;

  localparam int NUM_NODES = 16;
  localparam int IDX_W     = $clog2(NUM_NODES);
  localparam int SCAN_W    = $clog2(NUM_NODES + 1);
  localparam int NODE_W    = 4;
  localparam int ACK_W     = 64;
  localparam int QSIZE_W   = 5;
  localparam int CNT_W     = 5;
  localparam int CMD_W     = 2;
  localparam int STS_W     = 2;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

  localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STS_W-1:0] STS_STALE = 2'd1;
  localparam logic [STS_W-1:0] STS_ZERO  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_QUORUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } rank_ctl_t;

endpackage

// ===== rtl/quorum_ack_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quorum_ack_tracker
// Per-node acknowledgment table with quorum ack tracking and queries.
// ----------------------------------------------------------------------------
// One request is handled at a time. A read goes from acceptance through the
// READ state to FIN and the result. A successful update or a count of a
// nonzero value sweeps the 16-entry node table through the RAM's single
// read port, one entry per cycle, then drains the last read; an update ranks
// the acks during the sweep and then passes the QUORUM state to raise the
// quorum ack. Rejected updates skip the sweep. The result sits in an output
// register, so the next request is accepted while a result still waits to
// be taken. Node entries start out unreported through per-entry valid bits;
// no clearing pass is needed after reset. The quorum ack never decreases and,
// once valid, stays valid; a new quorum size applies at the next QUORUM state.
// ----------------------------------------------------------------------------
module quorum_ack_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [qat_pkg::CMD_W-1:0]   in_cmd,
  input  logic [qat_pkg::NODE_W-1:0]  in_node_id,
  input  logic [qat_pkg::ACK_W-1:0]   in_ack_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [qat_pkg::STS_W-1:0]   out_status,
  output logic                        out_node_ack_valid,
  output logic [qat_pkg::ACK_W-1:0]   out_node_ack,
  output logic [qat_pkg::CNT_W-1:0]   out_nodes_at_value,
  output logic                        out_quorum_valid,
  output logic [qat_pkg::ACK_W-1:0]   out_quorum_ack,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qat_pkg::QSIZE_W-1:0] cfg_quorum_size
);

  qat_pkg::state_t state_r, state_nxt;

  logic [qat_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [qat_pkg::NODE_W-1:0]  node_r, node_nxt;
  logic [qat_pkg::ACK_W-1:0]   val_r, val_nxt;
  logic [qat_pkg::STS_W-1:0]   status_r, status_nxt;
  logic [qat_pkg::ACK_W-1:0]   nack_r, nack_nxt;
  logic [qat_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [qat_pkg::SCAN_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic                        vld_q_r;
  logic [qat_pkg::ACK_W-1:0]   q_ack_r, q_ack_nxt;
  logic                        q_valid_r, q_valid_nxt;
  logic [qat_pkg::QSIZE_W-1:0] qsize_r;
  logic [qat_pkg::NUM_NODES-1:0] node_vld_r;

  logic                        out_valid_r;
  logic [qat_pkg::STS_W-1:0]   out_status_r;
  logic [qat_pkg::ACK_W-1:0]   out_node_ack_r;
  logic [qat_pkg::CNT_W-1:0]   out_cnt_r;
  logic                        out_q_valid_r;
  logic [qat_pkg::ACK_W-1:0]   out_q_ack_r;
  logic                        out_load;

  logic                        ram_we;
  logic [qat_pkg::IDX_W-1:0]   ram_waddr;
  logic [qat_pkg::ACK_W-1:0]   ram_wdata;
  logic [qat_pkg::IDX_W-1:0]   ram_raddr;
  logic [qat_pkg::ACK_W-1:0]   ram_rdata;

  qat_pkg::rank_ctl_t          rank_ctl;
  logic [qat_pkg::ACK_W-1:0]   kth_value;
  logic                        kth_found;

  logic [qat_pkg::ACK_W-1:0]   cur;
  logic                        in_range;
  logic                        upd_ok;
  logic                        scan_go;
  logic                        scan_last;

  qat_ram #(
    .WIDTH (qat_pkg::ACK_W),
    .DEPTH (qat_pkg::NUM_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qat_rank u_rank (
    .clk       (clk),
    .ctl       (rank_ctl),
    .ins_value (cur),
    .qsize     (qsize_r),
    .kth_value (kth_value),
    .kth_found (kth_found)
  );

  // unreported entries read as zero
  assign cur       = vld_q_r ? ram_rdata : '0;
  assign in_range  = 32'(node_r) < qat_pkg::NUM_NODES;
  assign upd_ok    = (cmd_r == qat_pkg::CMD_UPDATE) && (val_r != '0) && in_range &&
                     (val_r > cur);
  assign scan_go   = upd_ok || ((cmd_r == qat_pkg::CMD_COUNT) && (val_r != '0));
  assign scan_last = scan_cnt_r == qat_pkg::SCAN_W'(qat_pkg::NUM_NODES - 1);
  assign out_load  = (state_r == qat_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  assign in_stall  = state_r != qat_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qat_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = qat_pkg::ST_READ;
        end
      end
      qat_pkg::ST_READ: begin
        state_nxt = scan_go ? qat_pkg::ST_SCAN : qat_pkg::ST_FIN;
      end
      qat_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = qat_pkg::ST_DRAIN;
        end
      end
      qat_pkg::ST_DRAIN: begin
        state_nxt = (cmd_r == qat_pkg::CMD_UPDATE) ? qat_pkg::ST_QUORUM : qat_pkg::ST_FIN;
      end
      qat_pkg::ST_QUORUM: begin
        state_nxt = qat_pkg::ST_FIN;
      end
      qat_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = qat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qat_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt      = cmd_r;
    node_nxt     = node_r;
    val_nxt      = val_r;
    status_nxt   = status_r;
    nack_nxt     = nack_r;
    cnt_nxt      = cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    pend_nxt     = 1'b0;
    q_ack_nxt    = q_ack_r;
    q_valid_nxt  = q_valid_r;
    ram_we       = 1'b0;
    ram_waddr    = node_r[qat_pkg::IDX_W-1:0];
    ram_wdata    = val_r;
    ram_raddr    = scan_cnt_r[qat_pkg::IDX_W-1:0];
    rank_ctl     = '0;

    unique case (state_r)
      qat_pkg::ST_IDLE: begin
        ram_raddr = in_node_id[qat_pkg::IDX_W-1:0];
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          node_nxt   = in_node_id;
          val_nxt    = in_ack_value;
          status_nxt = qat_pkg::STS_DONE;
          cnt_nxt    = '0;
        end
      end
      qat_pkg::ST_READ: begin
        nack_nxt     = in_range ? cur : '0;
        scan_cnt_nxt = '0;
        if (cmd_r == qat_pkg::CMD_UPDATE) begin
          priority if (val_r == '0) begin
            status_nxt = qat_pkg::STS_ZERO;
          end else if (!upd_ok) begin
            status_nxt = qat_pkg::STS_STALE;
          end else begin
            ram_we       = 1'b1;
            nack_nxt     = val_r;
            rank_ctl.clr = 1'b1;
          end
        end
      end
      qat_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + qat_pkg::SCAN_W'(1);
        pend_nxt     = 1'b1;
      end
      qat_pkg::ST_QUORUM: begin
        if (kth_found) begin
          q_valid_nxt = 1'b1;
          if (!q_valid_r || (kth_value > q_ack_r)) begin
            q_ack_nxt = kth_value;
          end
        end
      end
      qat_pkg::ST_DRAIN, qat_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase

    // consume scan data in the cycle after its address went out
    if (pend_r) begin
      if (cur == val_r) begin
        cnt_nxt = cnt_r + qat_pkg::CNT_W'(1);
      end
      rank_ctl.ins = cmd_r == qat_pkg::CMD_UPDATE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qat_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      q_ack_r     <= '0;
      q_valid_r   <= 1'b0;
      qsize_r     <= qat_pkg::QSIZE_W'(1);
      node_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      q_ack_r   <= q_ack_nxt;
      q_valid_r <= q_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        qsize_r <= cfg_quorum_size;
      end
      if (ram_we) begin
        node_vld_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    node_r     <= node_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    nack_r     <= nack_nxt;
    cnt_r      <= cnt_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    vld_q_r    <= node_vld_r[ram_raddr];
    if (out_load) begin
      out_status_r   <= status_r;
      out_node_ack_r <= nack_r;
      out_cnt_r      <= (cmd_r == qat_pkg::CMD_COUNT) ? cnt_r : '0;
      out_q_valid_r  <= q_valid_r;
      out_q_ack_r    <= q_valid_r ? q_ack_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_node_ack_valid = out_node_ack_r != '0;
  assign out_node_ack       = out_node_ack_r;
  assign out_nodes_at_value = out_cnt_r;
  assign out_quorum_valid   = out_q_valid_r;
  assign out_quorum_ack     = out_q_ack_r;

  // quorum ack only moves up and valid never drops
  a_quorum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_r |=> q_valid_r && (q_ack_r >= $past(q_ack_r)))
    else $error("quorum ack decreased or quorum valid cleared");

  // the table is written only while resolving an update
  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == qat_pkg::ST_READ) && (cmd_r == qat_pkg::CMD_UPDATE))
    else $error("node table written outside an update");

  // the last scan read is still in flight when draining
  a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qat_pkg::ST_DRAIN |-> pend_r)
    else $error("drain without pending scan data");

  // an accepted request always starts with the table lookup
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == qat_pkg::ST_READ)
    else $error("accepted request did not enter lookup");

endmodule

// ===== rtl/qat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/qat_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_rank
// Sorted insertion list: collects the acks of one table scan in descending
// order and picks the quorum_size-th largest reported ack.
// ----------------------------------------------------------------------------
module qat_rank (
  input  logic                        clk,
  input  qat_pkg::rank_ctl_t          ctl,
  input  logic [qat_pkg::ACK_W-1:0]   ins_value,
  input  logic [qat_pkg::QSIZE_W-1:0] qsize,
  output logic [qat_pkg::ACK_W-1:0]   kth_value,
  output logic                        kth_found
);

  logic [qat_pkg::ACK_W-1:0]   top_r   [qat_pkg::NUM_NODES];
  logic [qat_pkg::ACK_W-1:0]   top_nxt [qat_pkg::NUM_NODES];
  logic [qat_pkg::NUM_NODES-1:0] ge;
  logic [qat_pkg::QSIZE_W-1:0] need;
  logic [qat_pkg::QSIZE_W-1:0] need_m1;

  always_comb begin
    for (int j = 0; j < qat_pkg::NUM_NODES; j++) begin
      ge[j] = top_r[j] >= ins_value;
    end
    // list stays descending, so the new value lands after every entry >= it
    for (int j = 0; j < qat_pkg::NUM_NODES; j++) begin
      if (ctl.clr) begin
        top_nxt[j] = '0;
      end else if (!ctl.ins || ge[j]) begin
        top_nxt[j] = top_r[j];
      end else if (j == 0) begin
        top_nxt[j] = ins_value;
      end else if (ge[j-1]) begin
        top_nxt[j] = ins_value;
      end else begin
        top_nxt[j] = top_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < qat_pkg::NUM_NODES; j++) begin
      top_r[j] <= top_nxt[j];
    end
  end

  // a quorum size of zero counts as one
  assign need    = (qsize == '0) ? qat_pkg::QSIZE_W'(1) : qsize;
  assign need_m1 = need - qat_pkg::QSIZE_W'(1);

  always_comb begin
    if (32'(need) > qat_pkg::NUM_NODES) begin
      kth_value = '0;
    end else begin
      kth_value = top_r[need_m1[qat_pkg::IDX_W-1:0]];
    end
    kth_found = kth_value != '0;
  end

endmodule
